/* rtl/rrsg_pkg.sv */
`timescale 1ns / 1ps

package rrsg_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned RADIUS_BITS    = 15;
  localparam int unsigned COLOR_BITS     = 24;

  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_RADIUS = 2'd1,
    STATUS_IDLE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_ERR_RADIUS = 2'd0,
    KIND_ERR_IDLE   = 2'd1,
    KIND_START      = 2'd2,
    KIND_STEP       = 2'd3
  } kind_e;

endpackage

/* rtl/rounded_rect_span_generator.sv */
`timescale 1ns / 1ps
// an accepted input goes to the item register, then each result is registered in the result register
// one result per cycle while the receiver is ready; an advance gives four results, a start three, an error one
// a new item is taken in the cycle its predecessor's final result is loaded for output
// the midpoint state advances with one short add chain at input transfer time
// reset: rst_ni asynchronous active low, clears latched geometry, midpoint state and armed

module rounded_rect_span_generator #(
  parameter int unsigned COORD_BITS = rrsg_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             func_i,
  input  logic [COORD_BITS-1:0]            pos_x_i,
  input  logic [COORD_BITS-1:0]            pos_y_i,
  input  logic [COORD_BITS-1:0]            box_w_i,
  input  logic [COORD_BITS-1:0]            box_h_i,
  input  logic [rrsg_pkg::RADIUS_BITS-1:0] radius_i,
  input  logic [rrsg_pkg::COLOR_BITS-1:0]  fill_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [COORD_BITS-1:0]            rect_x_o,
  output logic [COORD_BITS-1:0]            rect_y_o,
  output logic [COORD_BITS-1:0]            rect_w_o,
  output logic [COORD_BITS-1:0]            rect_h_o,
  output logic [rrsg_pkg::COLOR_BITS-1:0]  rect_color_o,
  output logic                             rect_valid_o,
  output logic                             last_o,
  output logic                             done_res_o,
  output logic [1:0]                       status_o
);
  import rrsg_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned RB = (COORD_BITS < RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;
  localparam int unsigned DW = CB + 4;
  localparam int unsigned SW = CB + 2;
  localparam int unsigned PW = CB + 1;

  // latched geometry and midpoint state
  logic [CB-1:0]         orgx_q, orgy_q, hgt_q, rad_q;
  logic [COLOR_BITS-1:0] col_q;
  logic signed [DW-1:0]  dec_q, dec_d;
  logic signed [SW-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic signed [PW-1:0]  cx_q, cx_d, cy_q, cy_d;
  logic                  armed_q;

  // item register
  logic                  itm_valid_q;
  kind_e                 kind_q, kind_d;
  logic [CB-1:0]         ix_q, ix_d, iy_q, iy_d, iw_q, iw_d, ih_q, ih_d, ir_q, ir_d;
  logic [CB-1:0]         ipx_q, ipx_d, ipy_q, ipy_d;
  logic [COLOR_BITS-1:0] ic_q, ic_d;
  logic                  idone_q, idone_d;
  logic [1:0]            cnt_q;

  // result register
  logic                  out_valid_q;
  logic [CB-1:0]         rx_q, ry_q, rw_q, rh_q;
  logic [COLOR_BITS-1:0] rc_q;
  logic                  rvalid_q, rlast_q, rdone_q;
  status_e               rstat_q;

  logic                  accept, emit, is_last;
  logic [CB-1:0]         r_in;
  logic                  r_err, dpos, step_done;

  logic [CB-1:0]         ex, ey, ew, eh;
  logic [COLOR_BITS-1:0] ec;
  logic                  evalid, edone;
  status_e               estat;
  logic [CB-1:0]         two_ir, two_px, two_py, xr, yr, yhr;

  assign emit       = itm_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !itm_valid_q || (emit && is_last);
  assign accept     = in_valid_i && in_ready_o;

  assign r_in  = CB'(radius_i[RB-1:0]);
  assign r_err = ({r_in, 1'b0} > {1'b0, box_w_i}) || ({r_in, 1'b0} > {1'b0, box_h_i});

  // one midpoint step
  always_comb begin
    dpos  = !dec_q[DW-1];
    cy_d  = dpos ? cy_q - PW'(1) : cy_q;
    sy_d  = dpos ? sy_q + SW'(2) : sy_q;
    sx_d  = sx_q + SW'(2);
    cx_d  = cx_q + PW'(1);
    dec_d = dec_q + (dpos ? DW'(sy_d) : '0) + DW'(sx_d);
    step_done = !(cx_d < cy_d);
  end

  always_comb begin
    kind_d  = KIND_STEP;
    ix_d    = orgx_q;
    iy_d    = orgy_q;
    iw_d    = box_w_i;
    ih_d    = hgt_q;
    ir_d    = rad_q;
    ic_d    = col_q;
    ipx_d   = cx_d[CB-1:0];
    ipy_d   = cy_d[CB-1:0];
    idone_d = step_done;
    if (func_i == FUNC_START) begin
      kind_d  = r_err ? KIND_ERR_RADIUS : KIND_START;
      ix_d    = pos_x_i;
      iy_d    = pos_y_i;
      ih_d    = box_h_i;
      ir_d    = r_in;
      ic_d    = fill_i;
      idone_d = (r_in == '0);
    end else if (!armed_q) begin
      kind_d = KIND_ERR_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orgx_q  <= '0;
      orgy_q  <= '0;
      hgt_q   <= '0;
      rad_q   <= '0;
      col_q   <= '0;
      dec_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      armed_q <= 1'b0;
    end else if (accept) begin
      if (func_i == FUNC_START) begin
        if (r_err) begin
          armed_q <= 1'b0;
        end else begin
          orgx_q  <= pos_x_i;
          orgy_q  <= pos_y_i;
          hgt_q   <= box_h_i;
          rad_q   <= r_in;
          col_q   <= fill_i;
          dec_q   <= DW'(1) - DW'(r_in);
          sx_q    <= SW'(1);
          sy_q    <= SW'(0) - SW'({r_in, 1'b0});
          cx_q    <= '0;
          cy_q    <= PW'(r_in);
          armed_q <= (r_in != '0);
        end
      end else if (armed_q) begin
        dec_q <= dec_d;
        sx_q  <= sx_d;
        sy_q  <= sy_d;
        cx_q  <= cx_d;
        cy_q  <= cy_d;
        if (step_done) begin
          armed_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itm_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (accept) begin
        itm_valid_q <= 1'b1;
      end else if (emit && is_last) begin
        itm_valid_q <= 1'b0;
      end
      if (emit) begin
        cnt_q <= is_last ? 2'd0 : cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_d;
      ix_q    <= ix_d;
      iy_q    <= iy_d;
      iw_q    <= iw_d;
      ih_q    <= ih_d;
      ir_q    <= ir_d;
      ic_q    <= ic_d;
      ipx_q   <= ipx_d;
      ipy_q   <= ipy_d;
      idone_q <= idone_d;
    end
  end

  // result selection for the current item and index
  assign two_ir = {ir_q[CB-2:0], 1'b0};
  assign two_px = {ipx_q[CB-2:0], 1'b0};
  assign two_py = {ipy_q[CB-2:0], 1'b0};
  assign xr     = ix_q + ir_q;
  assign yr     = iy_q + ir_q;
  assign yhr    = iy_q + ih_q - ir_q - CB'(1);

  always_comb begin
    ex      = '0;
    ey      = '0;
    ew      = '0;
    eh      = '0;
    ec      = '0;
    evalid  = 1'b0;
    edone   = 1'b1;
    estat   = STATUS_OK;
    is_last = 1'b1;
    case (kind_q)
      KIND_ERR_RADIUS: begin
        estat = STATUS_RADIUS;
      end
      KIND_ERR_IDLE: begin
        estat = STATUS_IDLE;
      end
      KIND_START: begin
        ec      = ic_q;
        evalid  = 1'b1;
        edone   = idone_q;
        is_last = (cnt_q == 2'd2);
        case (cnt_q)
          2'd0: begin
            ex = xr;
            ey = iy_q;
            ew = iw_q - two_ir;
            eh = ih_q;
          end
          2'd1: begin
            ex = ix_q;
            ey = yr;
            ew = ir_q;
            eh = ih_q - two_ir;
          end
          default: begin
            ex = ix_q + iw_q - ir_q;
            ey = yr;
            ew = ir_q;
            eh = ih_q - two_ir;
          end
        endcase
      end
      KIND_STEP: begin
        ec      = ic_q;
        evalid  = 1'b1;
        edone   = idone_q;
        eh      = CB'(1);
        is_last = (cnt_q == 2'd3);
        case (cnt_q)
          2'd0: begin
            ex = xr - ipx_q;
            ey = yr - ipy_q;
            ew = two_px;
          end
          2'd1: begin
            ex = xr - ipx_q;
            ey = yhr + ipy_q;
            ew = two_px;
          end
          2'd2: begin
            ex = xr - ipy_q;
            ey = yr - ipx_q;
            ew = two_py;
          end
          default: begin
            ex = xr - ipy_q;
            ey = yhr + ipx_q;
            ew = two_py;
          end
        endcase
      end
      default: begin
        estat = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rx_q     <= ex;
      ry_q     <= ey;
      rw_q     <= ew;
      rh_q     <= eh;
      rc_q     <= ec;
      rvalid_q <= evalid;
      rlast_q  <= is_last;
      rdone_q  <= edone;
      rstat_q  <= estat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign rect_x_o     = rx_q;
  assign rect_y_o     = ry_q;
  assign rect_w_o     = rw_q;
  assign rect_h_o     = rh_q;
  assign rect_color_o = rc_q;
  assign rect_valid_o = rvalid_q;
  assign last_o       = rlast_q;
  assign done_res_o   = rdone_q;
  assign status_o     = rstat_q;

endmodule

/* rtl/rrsg_checker.sv */
`timescale 1ns / 1ps

module rrsg_checker #(
  parameter int unsigned COORD_BITS = rrsg_pkg::COORD_BITS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [COORD_BITS-1:0]            rect_x_o,
  input logic [COORD_BITS-1:0]            rect_y_o,
  input logic [COORD_BITS-1:0]            rect_w_o,
  input logic [COORD_BITS-1:0]            rect_h_o,
  input logic [rrsg_pkg::COLOR_BITS-1:0]  rect_color_o,
  input logic                             rect_valid_o,
  input logic                             last_o,
  input logic                             done_res_o,
  input logic [1:0]                       status_o
);
  import rrsg_pkg::*;

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rect_x_o) && $stable(rect_y_o)
      && $stable(rect_w_o) && $stable(rect_h_o) && $stable(rect_color_o)
      && $stable(rect_valid_o) && $stable(done_res_o) && $stable(status_o)
      && $stable(last_o))
    else $error("result changed while stalled");

  // error results carry no rectangle and end their item
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK)
      |-> !rect_valid_o && last_o && done_res_o && (rect_w_o == '0) && (rect_h_o == '0))
    else $error("error result malformed");

  // ok results always carry a rectangle
  a_ok_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_OK) |-> rect_valid_o)
    else $error("ok result without rectangle");

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result visible after reset");

endmodule

bind rounded_rect_span_generator rrsg_checker #(.COORD_BITS(COORD_BITS)) u_rrsg_checker (.*);

/* test/tb_rounded_rect_span_generator.sv */
`timescale 1ns / 1ps

module tb_rounded_rect_span_generator;
  import rrsg_pkg::*;

  localparam int unsigned CB          = COORD_BITS_DEF;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned N_RANDOM    = 130;

  typedef logic [CB-1:0]          coord_t;
  typedef logic [RADIUS_BITS-1:0] rad_t;
  typedef logic [COLOR_BITS-1:0]  color_t;

  typedef struct {
    func_e  func;
    coord_t x, y, w, h;
    rad_t   r;
    color_t c;
    int     gap;
    bit     drain;
  } shape_item_t;

  typedef struct {
    coord_t  x, y, w, h;
    color_t  c;
    logic    vld, last, done;
    status_e status;
  } span_t;

  logic   clk_i        = 1'b0;
  logic   rst_ni       = 1'b0;
  logic   in_valid_i   = 1'b0;
  logic   in_ready_o;
  logic   func_i       = 1'b0;
  coord_t pos_x_i      = '0;
  coord_t pos_y_i      = '0;
  coord_t box_w_i      = '0;
  coord_t box_h_i      = '0;
  rad_t   radius_i     = '0;
  color_t fill_i       = '0;
  logic   out_valid_o;
  logic   out_ready_i  = 1'b0;
  coord_t rect_x_o, rect_y_o, rect_w_o, rect_h_o;
  color_t rect_color_o;
  logic   rect_valid_o, last_o, done_res_o;
  logic [1:0] status_o;

  rounded_rect_span_generator #(.COORD_BITS(CB)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .box_w_i      (box_w_i),
    .box_h_i      (box_h_i),
    .radius_i     (radius_i),
    .fill_i       (fill_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .rect_x_o     (rect_x_o),
    .rect_y_o     (rect_y_o),
    .rect_w_o     (rect_w_o),
    .rect_h_o     (rect_h_o),
    .rect_color_o (rect_color_o),
    .rect_valid_o (rect_valid_o),
    .last_o       (last_o),
    .done_res_o   (done_res_o),
    .status_o     (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  shape_item_t item_q[$];
  span_t       span_q[$];
  shape_item_t nxt_item;
  int          n_items    = 0;
  int          n_taken    = 0;
  int          errors     = 0;
  int          gap_left   = 0;
  int          stall_left = 0;
  bit          in_taken   = 1'b0;
  bit          calm_tx    = 1'b0;
  bit          calm_rx    = 1'b1;

  // shape latched by the last good start, plus midpoint loop state
  coord_t org_x   = '0;
  coord_t org_y   = '0;
  coord_t box_hgt = '0;
  coord_t rad_q   = '0;
  color_t col_q   = '0;
  int     dcs     = 0;
  int     inc_x   = 0;
  int     inc_y   = 0;
  int     mx      = 0;
  int     my      = 0;
  bit     running = 1'b0;

  task automatic report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic void push_span(int x, int y, int w, int h, color_t c, logic vld,
                                    logic last, logic done, status_e st);
    span_t s;
    s.x      = coord_t'(x);
    s.y      = coord_t'(y);
    s.w      = coord_t'(w);
    s.h      = coord_t'(h);
    s.c      = c;
    s.vld    = vld;
    s.last   = last;
    s.done   = done;
    s.status = st;
    span_q.push_back(s);
  endfunction

  function automatic void plan_spans(func_e fn, coord_t x, coord_t y, coord_t w,
                                     coord_t h, rad_t rin, color_t c);
    int   r;
    logic done;
    r = int'(rin);
    if (fn == FUNC_START) begin
      if (2 * r > int'(w) || 2 * r > int'(h)) begin
        running = 1'b0;
        push_span(0, 0, 0, 0, '0, 1'b0, 1'b1, 1'b1, STATUS_RADIUS);
      end else begin
        org_x   = x;
        org_y   = y;
        box_hgt = h;
        rad_q   = coord_t'(r);
        col_q   = c;
        dcs     = 1 - r;
        inc_x   = 1;
        inc_y   = -2 * r;
        mx      = 0;
        my      = r;
        running = (r > 0);
        done    = !running;
        push_span(x + r, y, w - 2 * r, h, c, 1'b1, 1'b0, done, STATUS_OK);
        push_span(x, y + r, r, h - 2 * r, c, 1'b1, 1'b0, done, STATUS_OK);
        push_span(x + w - r, y + r, r, h - 2 * r, c, 1'b1, 1'b1, done, STATUS_OK);
      end
    end else if (!running) begin
      push_span(0, 0, 0, 0, '0, 1'b0, 1'b1, 1'b1, STATUS_IDLE);
    end else begin
      if (dcs >= 0) begin
        my--;
        inc_y += 2;
        dcs   += inc_y;
      end
      mx++;
      inc_x += 2;
      dcs   += inc_x;
      done = (mx < my) ? 1'b0 : 1'b1;
      push_span(org_x + rad_q - mx, org_y + rad_q - my, 2 * mx, 1, col_q,
                1'b1, 1'b0, done, STATUS_OK);
      push_span(org_x + rad_q - mx, org_y + box_hgt - rad_q + my - 1, 2 * mx, 1, col_q,
                1'b1, 1'b0, done, STATUS_OK);
      push_span(org_x + rad_q - my, org_y + rad_q - mx, 2 * my, 1, col_q,
                1'b1, 1'b0, done, STATUS_OK);
      push_span(org_x + rad_q - my, org_y + box_hgt - rad_q + mx - 1, 2 * my, 1, col_q,
                1'b1, 1'b1, done, STATUS_OK);
      if (done) running = 1'b0;
    end
  endfunction

  function automatic void add_item(func_e fn, int x, int y, int w, int h, int r, int c,
                                   bit drain);
    shape_item_t it;
    it.func  = fn;
    it.x     = coord_t'(x);
    it.y     = coord_t'(y);
    it.w     = coord_t'(w);
    it.h     = coord_t'(h);
    it.r     = rad_t'(r);
    it.c     = color_t'(c);
    it.gap   = calm_tx ? 0 : $urandom_range(0, 16);
    it.drain = drain;
    item_q.push_back(it);
  endfunction

  // sender: payload and valid change on the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (item_q.size() != 0 && !(item_q[0].drain && span_q.size() != 0)) begin
        nxt_item = item_q.pop_front();
        func_i   <= nxt_item.func;
        pos_x_i  <= nxt_item.x;
        pos_y_i  <= nxt_item.y;
        box_w_i  <= nxt_item.w;
        box_h_i  <= nxt_item.h;
        radius_i <= nxt_item.r;
        fill_i   <= nxt_item.c;
        gap_left = nxt_item.gap;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // input transfers feed the predictor, output transfers are checked
  always @(posedge clk_i) begin
    span_t s;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) begin
      plan_spans(func_e'(func_i), pos_x_i, pos_y_i, box_w_i, box_h_i, radius_i, fill_i);
      n_taken++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (span_q.size() == 0) begin
        report("output transfer with nothing expected");
      end else begin
        s = span_q.pop_front();
        if (rect_x_o !== s.x)
          report($sformatf("rect_x %0h, expected %0h", rect_x_o, s.x));
        if (rect_y_o !== s.y)
          report($sformatf("rect_y %0h, expected %0h", rect_y_o, s.y));
        if (rect_w_o !== s.w)
          report($sformatf("rect_w %0h, expected %0h", rect_w_o, s.w));
        if (rect_h_o !== s.h)
          report($sformatf("rect_h %0h, expected %0h", rect_h_o, s.h));
        if (rect_color_o !== s.c)
          report($sformatf("rect_color %0h, expected %0h", rect_color_o, s.c));
        if (rect_valid_o !== s.vld)
          report($sformatf("rect_valid %0b, expected %0b", rect_valid_o, s.vld));
        if (last_o !== s.last)
          report($sformatf("last %0b, expected %0b", last_o, s.last));
        if (done_res_o !== s.done)
          report($sformatf("done_res %0b, expected %0b", done_res_o, s.done));
        if (status_o !== s.status)
          report($sformatf("status %0d, expected %0d", status_o, s.status));
      end
      if ($urandom_range(0, 19) == 0) calm_rx = !calm_rx;
      stall_left = calm_rx ? 0 : $urandom_range(0, 16);
    end
  end

  initial begin
    int n_dir;
    int r;
    int w;
    int h;
    int n_adv;

    // directed corners
    add_item(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 1'b0);
    add_item(FUNC_START, 0, 0, 0, 0, 0, 0, 1'b0);
    add_item(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 1'b0);
    add_item(FUNC_START, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'h7FFF, 'hFFFFFF, 1'b0);
    add_item(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 1'b0);
    add_item(FUNC_ADVANCE, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'h7FFF, 'hFFFFFF, 1'b0);
    add_item(FUNC_START, 'hFFFF, 0, 'hFFFF, 'hFFFE, 'h7FFF, 'h123456, 1'b0);
    add_item(FUNC_START, 10, 20, 9, 100, 5, 'hABCDEF, 1'b0);
    add_item(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 1'b0);
    add_item(FUNC_START, 10, 20, 100, 9, 5, 'h00FF00, 1'b0);
    add_item(FUNC_START, 'hFFFE, 'hFFFD, 6, 6, 3, 'h5A5A5A, 1'b1);
    repeat (5) add_item(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 1'b0);
    add_item(FUNC_START, 1, 2, 2, 2, 1, 'hA5A5A5, 1'b0);
    repeat (2) add_item(FUNC_ADVANCE, 0, 0, 0, 0, 0, 0, 1'b0);
    n_dir = item_q.size();

    // mostly complete shapes with random content, some noise
    while (item_q.size() < n_dir + N_RANDOM) begin
      if ($urandom_range(0, 7) == 0) calm_tx = !calm_tx;
      if ($urandom_range(0, 4) == 0) begin
        add_item(func_e'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(0, 'h7FFF), $urandom, 1'b0);
      end else begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 12);
        w = 2 * r + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535 - 2 * r)
                                                 : $urandom_range(0, 40));
        h = 2 * r + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535 - 2 * r)
                                                 : $urandom_range(0, 40));
        add_item(FUNC_START, $urandom, $urandom, w, h, r, $urandom,
                 $urandom_range(0, 9) == 0);
        n_adv = (r > 12) ? $urandom_range(1, 6) : $urandom_range(r * 5 / 8, r * 3 / 4 + 2);
        repeat (n_adv) add_item(FUNC_ADVANCE, $urandom, $urandom, $urandom, $urandom,
                                $urandom_range(0, 'h7FFF), $urandom, 1'b0);
      end
    end
    n_items = item_q.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_taken != n_items) @(posedge clk_i);
    while (span_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
rtl/rrsg_pkg.sv
rtl/rounded_rect_span_generator.sv
rtl/rrsg_checker.sv
test/tb_rounded_rect_span_generator.sv
